@@ src/amrq_pkg.sv @@
// Shared constants, request and status codes for the array map with ring queue.
package amrq_pkg;

  localparam int DEPTH      = 1024;
  localparam int VALUE_BITS = 64;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int EC_W       = IDX_W + 1;
  localparam int CNT_W      = 11;
  localparam int KEY_W      = 32;
  localparam int RVAL_W     = 64;
  localparam int NEXT_W     = 10;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 80;
  localparam int CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(DEPTH);

  typedef enum logic [2:0] {
    REQ_LOOKUP  = 3'd0,
    REQ_UPDATE  = 3'd1,
    REQ_DELETE  = 3'd2,
    REQ_NEXTKEY = 3'd3,
    REQ_ENQ     = 3'd4,
    REQ_DEQ     = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_INVALID    = 3'd1,
    ST_EXISTS     = 3'd2,
    ST_NOENT      = 3'd3,
    ST_NOSPACE    = 3'd4,
    ST_WOULDBLOCK = 3'd5
  } status_t;

endpackage

@@ src/array_map_with_ring_queue.sv @@
// Top level: array table and ring queue sharing one value memory.
//
//  channel | dir | handshake              | contents
//  in_     | in  | in_tvalid/in_tready    | tuser: req_type; tdata: key, key_present,
//          |     |                        |   write_value, no_exist_flag
//  out_    | out | out_tvalid/out_tready  | tdata: status, read_value, next_index
//  cfg_    | in  | cfg_tvalid/cfg_tready  | tdata: entry_count
//
// One request per cycle while results are drained; a taken request passes through the
// memory access stage, then the output register. The single memory port sets the rate:
// each request makes at most one read or one write. A write is visible to a read issued
// in the next cycle, so no forwarding is needed.
// After reset a clearing pass writes zero to all 1024 entries, one per cycle; no
// request is taken during the pass. Configuration writes are always taken.
// A stalled output holds the pending word in the middle stage and drops in_tready.
module array_map_with_ring_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [2:0] req_type
  input  logic [2:0]                      in_tuser,
  // [31:0] key, [32] key_present, [96:33] write_value, [97] no_exist_flag
  input  logic [amrq_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [2:0] status, [66:3] read_value, [76:67] next_index
  output logic [amrq_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_tvalid,
  output logic                            cfg_tready,
  // [10:0] entry_count
  input  logic [amrq_pkg::CFG_DATA_W-1:0] cfg_tdata
);
  import amrq_pkg::*;

  // configuration
  logic [CNT_W-1:0] cnt_r;

  // clearing pass
  logic             clr_busy_r;
  logic [IDX_W-1:0] clr_idx_r;

  // ring pointers
  logic [IDX_W-1:0] prod_r, prod_nxt;
  logic [IDX_W-1:0] cons_r, cons_nxt;

  // memory stage
  logic             s1_v_r;
  status_t          s1_status_r, s1_status_nxt;
  logic [NEXT_W-1:0] s1_next_r, s1_next_nxt;
  logic             s1_rd_r, s1_rd_nxt;

  // output register
  logic              out_v_r;
  status_t           out_status_r;
  logic [RVAL_W-1:0] out_rval_r;
  logic [NEXT_W-1:0] out_next_r;

  // memory port
  logic                  ram_en, ram_we;
  logic [IDX_W-1:0]      ram_addr;
  logic [VALUE_BITS-1:0] ram_wdata, ram_rdata;

  // request decode
  req_t                  req;
  logic [KEY_W-1:0]      key;
  logic                  key_present;
  logic [VALUE_BITS-1:0] wval;
  logic                  no_exist;
  logic                  accept;
  logic                  out_free;

  logic [EC_W-1:0]  count;
  logic [EC_W-1:0]  cnt_m1;
  logic [KEY_W-1:0] count32;
  logic             key_in_range;
  logic [KEY_W-1:0] nk;
  logic             ring_full;
  logic [EC_W-1:0]  prod_step, cons_step;

  assign req         = req_t'(in_tuser);
  assign key         = in_tdata[31:0];
  assign key_present = in_tdata[32];
  assign wval        = in_tdata[33 +: VALUE_BITS];
  assign no_exist    = in_tdata[97];

  assign cfg_tready = 1'b1;
  assign out_free   = !out_v_r || out_tready;
  assign in_tready  = !clr_busy_r && (!s1_v_r || out_free);
  assign accept     = in_tvalid && in_tready;

  // saturate the count into 1..DEPTH
  always_comb begin
    if (cnt_r == '0) begin
      count = EC_W'(1);
    end else if (32'(cnt_r) > 32'(DEPTH)) begin
      count = EC_W'(DEPTH);
    end else begin
      count = EC_W'(cnt_r);
    end
  end

  assign cnt_m1       = count - EC_W'(1);
  assign count32      = KEY_W'(count);
  assign key_in_range = key < count32;
  assign nk           = key_present ? key : '1;

  assign prod_step = ({1'b0, prod_r} + EC_W'(1) >= count) ? '0 : {1'b0, prod_r} + EC_W'(1);
  assign cons_step = ({1'b0, cons_r} + EC_W'(1) >= count) ? '0 : {1'b0, cons_r} + EC_W'(1);

  always_comb begin
    if ({1'b0, prod_r} == cnt_m1) begin
      ring_full = (cons_r == '0);
    end else begin
      ring_full = (cons_r != '0) && ({1'b0, prod_r} + EC_W'(1) == {1'b0, cons_r});
    end
  end

  always_comb begin
    s1_status_nxt = ST_INVALID;
    s1_next_nxt   = '0;
    s1_rd_nxt     = 1'b0;
    prod_nxt      = prod_r;
    cons_nxt      = cons_r;
    ram_en        = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = key[IDX_W-1:0];
    ram_wdata     = wval;
    if (clr_busy_r) begin
      ram_en    = 1'b1;
      ram_we    = 1'b1;
      ram_addr  = clr_idx_r;
      ram_wdata = '0;
    end else if (accept) begin
      case (req)
        REQ_LOOKUP: begin
          if (key_in_range) begin
            ram_en        = 1'b1;
            s1_rd_nxt     = 1'b1;
            s1_status_nxt = ST_OK;
          end
        end
        REQ_UPDATE: begin
          if (no_exist) begin
            s1_status_nxt = ST_EXISTS;
          end else if (key_in_range) begin
            ram_en        = 1'b1;
            ram_we        = 1'b1;
            s1_status_nxt = ST_OK;
          end
        end
        REQ_NEXTKEY: begin
          if (nk >= count32) begin
            s1_status_nxt = ST_OK;
          end else if (nk == count32 - 32'd1) begin
            s1_status_nxt = ST_NOENT;
          end else begin
            s1_next_nxt   = NEXT_W'(nk + 32'd1);
            s1_status_nxt = ST_OK;
          end
        end
        REQ_ENQ: begin
          if (ring_full) begin
            s1_status_nxt = ST_NOSPACE;
          end else begin
            ram_en        = 1'b1;
            ram_we        = 1'b1;
            ram_addr      = prod_r;
            prod_nxt      = prod_step[IDX_W-1:0];
            s1_status_nxt = ST_OK;
          end
        end
        REQ_DEQ: begin
          if (cons_r == prod_r) begin
            s1_status_nxt = ST_WOULDBLOCK;
          end else begin
            ram_en        = 1'b1;
            ram_addr      = cons_r;
            s1_rd_nxt     = 1'b1;
            cons_nxt      = cons_step[IDX_W-1:0];
            s1_status_nxt = ST_OK;
          end
        end
        default: begin
          s1_status_nxt = ST_INVALID;
        end
      endcase
    end
  end

  amrq_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= CNT_RESET;
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
      prod_r     <= '0;
      cons_r     <= '0;
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (cfg_tvalid && cfg_tready) begin
        cnt_r <= cfg_tdata[CNT_W-1:0];
      end
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + IDX_W'(1);
        if (clr_idx_r == IDX_W'(DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      prod_r <= prod_nxt;
      cons_r <= cons_nxt;
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (out_free) begin
        s1_v_r <= 1'b0;
      end
      if (out_free) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= s1_status_nxt;
      s1_next_r   <= s1_next_nxt;
      s1_rd_r     <= s1_rd_nxt;
    end
    if (out_free && s1_v_r) begin
      out_status_r <= s1_status_r;
      out_next_r   <= s1_next_r;
      out_rval_r   <= s1_rd_r ? RVAL_W'(ram_rdata) : '0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, out_next_r, out_rval_r, out_status_r};

  a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_tready)
    else $error("request taken during clearing pass");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && out_v_r && !out_tready |=> s1_v_r && $stable(s1_status_r) && $stable(s1_next_r))
    else $error("pending word lost under output stall");

  a_rval_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_rval_r != '0 |-> out_status_r == ST_OK)
    else $error("read value on failed request");

  a_next_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_next_r != '0 |-> out_status_r == ST_OK)
    else $error("next index on failed request");

endmodule

@@ src/amrq_ram.sv @@
// Generic single-port RAM with registered read data.
module amrq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

@@ bench/tb.sv @@
// Testbench for array_map_with_ring_queue: directed and random requests checked against a model.
module tb;
  import amrq_pkg::*;

  localparam logic [2:0] REQ_BAD_LO = 3'd6;
  localparam logic [2:0] REQ_BAD_HI = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_PRINTS = 30;

  typedef struct packed {
    status_t           status;
    logic [RVAL_W-1:0] rdata;
    logic [NEXT_W-1:0] nxt_index;
  } map_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [2:0]            in_tuser = '0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_tvalid = 1'b0;
  logic                  cfg_tready;
  logic [CFG_DATA_W-1:0] cfg_tdata = '0;

  // model state: value table, ring indices, entry count register
  logic [VALUE_BITS-1:0] map_mem [DEPTH];
  logic [IDX_W-1:0]      head_idx;
  logic [IDX_W-1:0]      tail_idx;
  logic [CNT_W-1:0]      entry_count_q;

  map_result_t pending_responses [$];
  bit          steady = 1'b0;
  int          errors = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          cfg_writes = 0;
  int          cycle_count = 0;

  array_map_with_ring_queue uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses still pending", cycle_count,
               pending_responses.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 14);
  end

  function automatic logic [CNT_W-1:0] live_count();
    if (entry_count_q == 0) return CNT_W'(1);
    if (entry_count_q > DEPTH) return CNT_W'(DEPTH);
    return entry_count_q;
  endfunction

  function automatic void reset_model();
    foreach (map_mem[i]) map_mem[i] = '0;
    head_idx = '0;
    tail_idx = '0;
    entry_count_q = CNT_RESET;
  endfunction

  // apply one request to the model and return the response it must produce
  function automatic map_result_t apply_request(logic [2:0] rtype, logic [31:0] key, bit kp,
                                                logic [63:0] wv, bit nx);
    map_result_t r;
    logic [31:0] cnt;
    logic [31:0] k;
    logic [31:0] h;
    logic [31:0] t;
    logic [31:0] step;
    bit          full;
    cnt = 32'(live_count());
    h = 32'(head_idx);
    t = 32'(tail_idx);
    r.status = ST_INVALID;
    r.rdata = '0;
    r.nxt_index = '0;
    case (rtype)
      REQ_LOOKUP: begin
        if (key < cnt) begin
          r.rdata = map_mem[key[IDX_W-1:0]];
          r.status = ST_OK;
        end
      end
      REQ_UPDATE: begin
        if (nx) begin
          r.status = ST_EXISTS;
        end else if (key < cnt) begin
          map_mem[key[IDX_W-1:0]] = wv;
          r.status = ST_OK;
        end
      end
      REQ_NEXTKEY: begin
        k = kp ? key : 32'hFFFF_FFFF;
        if (k >= cnt) begin
          r.status = ST_OK;
        end else if (k == cnt - 1) begin
          r.status = ST_NOENT;
        end else begin
          r.nxt_index = NEXT_W'(k + 1);
          r.status = ST_OK;
        end
      end
      REQ_ENQ: begin
        if (h == cnt - 1) full = (t == 0);
        else full = (t != 0) && (h + 1 == t);
        if (full) begin
          r.status = ST_NOSPACE;
        end else begin
          map_mem[head_idx] = wv;
          step = h + 1;
          head_idx = (step >= cnt) ? '0 : IDX_W'(step);
          r.status = ST_OK;
        end
      end
      REQ_DEQ: begin
        if (t == h) begin
          r.status = ST_WOULDBLOCK;
        end else begin
          r.rdata = map_mem[tail_idx];
          step = t + 1;
          tail_idx = (step >= cnt) ? '0 : IDX_W'(step);
          r.status = ST_OK;
        end
      end
      default: r.status = ST_INVALID;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (errors < MAX_PRINTS)
      $display("mismatch at cycle %0d, response %0d: %s got 0x%0h want 0x%0h", cycle_count,
               results_seen, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    map_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_responses.size() == 0) begin
        report_mismatch("unexpected word", 64'(out_tdata[2:0]), '0);
      end else begin
        want = pending_responses.pop_front();
        if (out_tdata[2:0] !== want.status)
          report_mismatch("status", 64'(out_tdata[2:0]), 64'(want.status));
        if (out_tdata[66:3] !== want.rdata)
          report_mismatch("read_value", out_tdata[66:3], want.rdata);
        if (out_tdata[76:67] !== want.nxt_index)
          report_mismatch("next_index", 64'(out_tdata[76:67]), 64'(want.nxt_index));
      end
    end
  end

  task automatic send_request(input logic [2:0] rtype, input logic [31:0] key, input bit kp,
                              input logic [63:0] wv, input bit nx);
    while (!steady && $urandom_range(99) < 14) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= rtype;
    in_tdata <= {6'd0, nx, wv, kp, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_responses.push_back(apply_request(rtype, key, kp, wv, nx));
    items_sent++;
  endtask

  // hold the sender until every response is back and the pipeline is empty
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_entry_count(input logic [CNT_W-1:0] value);
    cfg_tvalid <= 1'b1;
    cfg_tdata <= {{(CFG_DATA_W-CNT_W){1'b0}}, value};
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    entry_count_q = value;
    cfg_writes++;
    cfg_tvalid <= 1'b0;
  endtask

  // table requests at the reset entry count of 1024
  task automatic test_table_directed();
    send_request(REQ_LOOKUP, 32'd0, 1'b1, 64'd0, 1'b0);
    send_request(REQ_UPDATE, 32'd0, 1'b0, '1, 1'b0);
    send_request(REQ_LOOKUP, 32'd0, 1'b0, 64'd0, 1'b1);
    send_request(REQ_UPDATE, 32'd1023, 1'b1, 64'h8000_0000_0000_0001, 1'b0);
    send_request(REQ_LOOKUP, 32'd1023, 1'b1, 64'd0, 1'b0);
    send_request(REQ_LOOKUP, 32'd1024, 1'b1, 64'd0, 1'b0);
    send_request(REQ_UPDATE, 32'hFFFF_FFFF, 1'b1, 64'h1234, 1'b0);
    // the no-exist flag wins over an out-of-range key
    send_request(REQ_UPDATE, 32'hFFFF_FFFF, 1'b0, 64'd5, 1'b1);
    send_request(REQ_DELETE, 32'd0, 1'b1, 64'd0, 1'b0);
    send_request(REQ_NEXTKEY, 32'd7, 1'b0, 64'd0, 1'b0);
    send_request(REQ_NEXTKEY, 32'd0, 1'b1, 64'd0, 1'b0);
    send_request(REQ_NEXTKEY, 32'd1022, 1'b1, 64'd0, 1'b0);
    send_request(REQ_NEXTKEY, 32'd1023, 1'b1, 64'd0, 1'b0);
    send_request(REQ_NEXTKEY, 32'd1024, 1'b1, 64'd0, 1'b0);
    send_request(REQ_BAD_LO, 32'd0, 1'b1, 64'd9, 1'b0);
    send_request(REQ_BAD_HI, 32'd1, 1'b0, 64'd9, 1'b1);
  endtask

  task automatic test_queue_directed();
    // two entries: the ring holds one word
    wait_idle();
    write_entry_count(11'd2);
    send_request(REQ_DEQ, 32'd0, 1'b0, 64'd0, 1'b0);
    send_request(REQ_ENQ, 32'd0, 1'b0, 64'hAAAA_0000_0000_0001, 1'b0);
    send_request(REQ_ENQ, 32'd0, 1'b0, 64'hBBBB_0000_0000_0002, 1'b0);
    send_request(REQ_DEQ, 32'd0, 1'b0, 64'd0, 1'b0);
    send_request(REQ_ENQ, 32'd0, 1'b0, 64'hCCCC_0000_0000_0003, 1'b0);
    send_request(REQ_DEQ, 32'd0, 1'b0, 64'd0, 1'b0);
    // a count of zero acts as one: always full and empty
    wait_idle();
    write_entry_count(11'd0);
    send_request(REQ_ENQ, 32'd0, 1'b0, 64'hDDDD, 1'b0);
    send_request(REQ_DEQ, 32'd0, 1'b0, 64'd0, 1'b0);
    // leave the producer past a count that is then lowered
    wait_idle();
    write_entry_count(11'd8);
    send_request(REQ_ENQ, 32'd0, 1'b0, 64'h1111, 1'b0);
    send_request(REQ_ENQ, 32'd0, 1'b0, 64'h2222, 1'b0);
    send_request(REQ_ENQ, 32'd0, 1'b0, 64'h3333, 1'b0);
    send_request(REQ_DEQ, 32'd0, 1'b0, 64'd0, 1'b0);
    wait_idle();
    write_entry_count(11'd2);
    send_request(REQ_ENQ, 32'd0, 1'b0, 64'h4444, 1'b0);
    send_request(REQ_DEQ, 32'd0, 1'b0, 64'd0, 1'b0);
    send_request(REQ_DEQ, 32'd0, 1'b0, 64'd0, 1'b0);
  endtask

  task automatic run_random_phase(input logic [CNT_W-1:0] count, input int n_items,
                                  input int enq_pct, input bit quiet, input bit mid_pause);
    logic [31:0] cnt;
    logic [2:0]  rtype;
    logic [31:0] key;
    logic [63:0] wv;
    int          roll;
    bit          kp;
    bit          nx;
    wait_idle();
    write_entry_count(count);
    steady = quiet;
    cnt = 32'(live_count());
    for (int i = 0; i < n_items; i++) begin
      if (mid_pause && i == n_items / 2) wait_idle();
      roll = $urandom_range(99);
      if (roll < 14) rtype = REQ_LOOKUP;
      else if (roll < 30) rtype = REQ_UPDATE;
      else if (roll < 34) rtype = REQ_DELETE;
      else if (roll < 46) rtype = REQ_NEXTKEY;
      else if (roll < 94) rtype = ($urandom_range(99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
      else rtype = $urandom_range(1) ? REQ_BAD_HI : REQ_BAD_LO;
      // bias keys toward the live range and its edges
      roll = $urandom_range(99);
      if (roll < 55) key = $urandom_range(cnt - 1);
      else if (roll < 65) key = cnt - 1;
      else if (roll < 72) key = cnt;
      else if (roll < 80) key = 0;
      else if (roll < 92) key = $urandom;
      else key = cnt + $urandom_range(8);
      roll = $urandom_range(99);
      if (roll < 10) wv = '1;
      else if (roll < 15) wv = '0;
      else wv = {$urandom, $urandom};
      kp = ($urandom_range(99) < 80);
      nx = (rtype == REQ_UPDATE) ? ($urandom_range(99) < 15) : 1'($urandom_range(1));
      send_request(rtype, key, kp, wv, nx);
    end
    steady = 1'b0;
  endtask

  task automatic test_random_phases();
    run_random_phase(11'd1024, 350, 75, 1'b0, 1'b0);
    run_random_phase(11'd16, 250, 60, 1'b0, 1'b1);
    run_random_phase(11'd2047, 150, 25, 1'b0, 1'b0);
    run_random_phase(11'd1, 100, 50, 1'b0, 1'b0);
    run_random_phase(11'd0, 60, 50, 1'b0, 1'b0);
    run_random_phase(11'd2, 150, 50, 1'b1, 1'b0);
    run_random_phase(11'd5, 200, 55, 1'b0, 1'b0);
    run_random_phase(CNT_W'($urandom_range(64, 3)), 250, 50, 1'b0, 1'b0);
    run_random_phase(CNT_W'($urandom_range(1024, 1)), 200, 50, 1'b0, 1'b0);
    run_random_phase(11'd3, 150, 40, 1'b0, 1'b0);
  endtask

  initial begin
    reset_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_table_directed();
    test_queue_directed();
    test_random_phases();
    in_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d requests, checked %0d responses, %0d entry-count writes",
             items_sent, results_seen, cfg_writes);
    $display("counts from 0 up to 2047, ring fill and drain, lowered counts, %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
